// File: rtl/pidpc_pkg.sv
// Package for the PID position controller: field widths, register
// indexes, reset values and the settle count. No dependencies.
package pidpc_pkg;

    // Field widths
    localparam int PosW   = 24;
    localparam int ErrW   = 25;
    localparam int GainW  = 16;
    localparam int CfgW   = 16;
    localparam int OlimW  = 7;
    localparam int DriveW = 8;
    localparam int IntegW = 17;
    localparam int SetW   = 5;
    localparam int ElapW  = 16;
    localparam int IdxW   = 3;

    // Derived arithmetic widths
    localparam int IAccW  = ErrW + 1;              // integral plus error
    localparam int DerW   = ErrW + 1;              // error minus previous error
    localparam int PPropW = GainW + ErrW;          // 41
    localparam int PIntW  = GainW + IntegW;        // 33
    localparam int PDerW  = GainW + DerW;          // 42
    localparam int SumW   = PDerW + 1;             // 43
    localparam int ShW    = SumW - 8;              // after floor shift by 8

    // Stream widths
    localparam int InDataW  = 48;
    localparam int OutDataW = 40;

    // Settle count and counter ceilings
    localparam logic [SetW-1:0]  SettleCount = 5'd20;
    localparam logic [SetW-1:0]  SettleMax   = 5'd31;
    localparam logic [ElapW-1:0] ElapMax     = 16'hFFFF;

    // Register indexes
    localparam logic [IdxW-1:0] RegPropGain  = 3'd0;
    localparam logic [IdxW-1:0] RegIntegGain = 3'd1;
    localparam logic [IdxW-1:0] RegDerivGain = 3'd2;
    localparam logic [IdxW-1:0] RegIntZone   = 3'd3;
    localparam logic [IdxW-1:0] RegIntLimit  = 3'd4;
    localparam logic [IdxW-1:0] RegOutLimit  = 3'd5;
    localparam logic [IdxW-1:0] RegSettleTol = 3'd6;
    localparam logic [IdxW-1:0] RegTimeout   = 3'd7;

    // Register reset values
    localparam logic [GainW-1:0] RstPropGain  = 16'd256;
    localparam logic [GainW-1:0] RstIntegGain = 16'd0;
    localparam logic [GainW-1:0] RstDerivGain = 16'd0;
    localparam logic [CfgW-1:0]  RstIntZone   = 16'd0;
    localparam logic [CfgW-1:0]  RstIntLimit  = 16'd1000;
    localparam logic [OlimW-1:0] RstOutLimit  = 7'd127;
    localparam logic [CfgW-1:0]  RstSettleTol = 16'd4;
    localparam logic [CfgW-1:0]  RstTimeout   = 16'd3000;

    // Per-item payload after the state stage
    typedef struct packed {
        logic signed [ErrW-1:0]   err;
        logic signed [IntegW-1:0] integ;
        logic signed [DerW-1:0]   deriv;
        logic                     done;
    } t_ctl_beat;

endpackage

// File: rtl/pid_position_controller_unit.sv
// PID position controller top level; depends on pidpc_pkg.
// A result beat passes through the input register, the state stage, the product stage
// and the output register, in that order.
// Throughput: one beat per cycle unless the output stalls; each stage moves whenever the next is free.
// Reset (i_rst_n low, synchronous): registers take their reset values, the
// integral, previous error and tick counters clear, all stages empty.
module pid_position_controller_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [23:0] setpoint, [47:24] measured
    input  logic [pidpc_pkg::InDataW-1:0]    i_s_axis_tdata,
    // [0] move_start
    input  logic                             i_s_axis_tuser,
    // Output stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] drive, [32:8] loop_error, [39:33] zero
    output logic [pidpc_pkg::OutDataW-1:0]   o_m_axis_tdata,
    // [0] done_res
    output logic                             o_m_axis_tuser,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pidpc_pkg::IdxW-1:0]       i_cfg_index,
    input  logic [pidpc_pkg::CfgW-1:0]       i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    logic signed [pidpc_pkg::GainW-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [pidpc_pkg::CfgW-1:0]         r_int_zone, r_int_limit, r_settle_tol, r_timeout;
    logic [pidpc_pkg::OlimW-1:0]        r_out_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= pidpc_pkg::RstPropGain;
            r_integ_gain <= pidpc_pkg::RstIntegGain;
            r_deriv_gain <= pidpc_pkg::RstDerivGain;
            r_int_zone   <= pidpc_pkg::RstIntZone;
            r_int_limit  <= pidpc_pkg::RstIntLimit;
            r_out_limit  <= pidpc_pkg::RstOutLimit;
            r_settle_tol <= pidpc_pkg::RstSettleTol;
            r_timeout    <= pidpc_pkg::RstTimeout;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pidpc_pkg::RegPropGain:  r_prop_gain  <= i_cfg_data;
                pidpc_pkg::RegIntegGain: r_integ_gain <= i_cfg_data;
                pidpc_pkg::RegDerivGain: r_deriv_gain <= i_cfg_data;
                pidpc_pkg::RegIntZone:   r_int_zone   <= i_cfg_data;
                pidpc_pkg::RegIntLimit:  r_int_limit  <= i_cfg_data;
                pidpc_pkg::RegOutLimit:  r_out_limit  <= i_cfg_data[pidpc_pkg::OlimW-1:0];
                pidpc_pkg::RegSettleTol: r_settle_tol <= i_cfg_data;
                pidpc_pkg::RegTimeout:   r_timeout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when empty or when it drains
    logic r_v1, r_v2, r_v3, r_vo;
    logic w_rdy_o, w_rdy3, w_rdy2, w_rdy1;

    assign w_rdy_o = !r_vo || i_m_axis_tready;
    assign w_rdy3  = !r_v3 || w_rdy_o;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1)  r_v1 <= i_s_axis_tvalid;
            if (w_rdy2)  r_v2 <= r_v1;
            if (w_rdy3)  r_v3 <= r_v2;
            if (w_rdy_o) r_vo <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    logic signed [pidpc_pkg::PosW-1:0] r_sp, r_ms;
    logic                              r_start;

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_sp    <= i_s_axis_tdata[pidpc_pkg::PosW-1:0];
            r_ms    <= i_s_axis_tdata[2*pidpc_pkg::PosW-1:pidpc_pkg::PosW];
            r_start <= i_s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: error, integral, derivative, tick counters (loop state)
    logic signed [pidpc_pkg::ErrW-1:0]   r_prev_err;
    logic signed [pidpc_pkg::IntegW-1:0] r_integ;
    logic [pidpc_pkg::SetW-1:0]          r_settled;
    logic [pidpc_pkg::ElapW-1:0]         r_elapsed;

    logic signed [pidpc_pkg::ErrW-1:0]   w_err;
    logic [pidpc_pkg::ErrW-1:0]          w_mag;
    logic signed [pidpc_pkg::IAccW-1:0]  w_iacc, w_ilim, w_iclamp;
    logic signed [pidpc_pkg::IntegW-1:0] n_integ;
    logic signed [pidpc_pkg::DerW-1:0]   w_deriv;
    logic [pidpc_pkg::SetW-1:0]          w_set_base, n_settled;
    logic [pidpc_pkg::ElapW-1:0]         w_elap_base, n_elapsed;
    logic                                w_done;
    logic                                w_step;
    pidpc_pkg::t_ctl_beat                r_ctl;

    assign w_step = r_v1 && w_rdy2;

    always_comb begin
        w_err = {r_sp[pidpc_pkg::PosW-1], r_sp} - {r_ms[pidpc_pkg::PosW-1], r_ms};
        w_mag = w_err[pidpc_pkg::ErrW-1] ? (~w_err + 1'b1) : w_err;

        // integrate inside the zone, else clear; then clamp to the limit
        w_ilim = {{(pidpc_pkg::IAccW-pidpc_pkg::CfgW){1'b0}}, r_int_limit};
        if (w_mag < {{(pidpc_pkg::ErrW-pidpc_pkg::CfgW){1'b0}}, r_int_zone})
            w_iacc = pidpc_pkg::IAccW'(r_integ) + pidpc_pkg::IAccW'(w_err);
        else
            w_iacc = '0;
        if (w_iacc > w_ilim)
            w_iclamp = w_ilim;
        else if (w_iacc < -w_ilim)
            w_iclamp = -w_ilim;
        else
            w_iclamp = w_iacc;
        n_integ = w_iclamp[pidpc_pkg::IntegW-1:0];

        w_deriv = pidpc_pkg::DerW'(w_err) - pidpc_pkg::DerW'(r_prev_err);

        // counters restart on the first tick of a move
        w_set_base  = r_start ? '0 : r_settled;
        w_elap_base = r_start ? '0 : r_elapsed;
        n_settled = w_set_base;
        if (w_mag <= {{(pidpc_pkg::ErrW-pidpc_pkg::CfgW){1'b0}}, r_settle_tol}
            && w_set_base < pidpc_pkg::SettleMax)
            n_settled = w_set_base + 1'b1;
        w_done = (n_settled >= pidpc_pkg::SettleCount) || (w_elap_base > r_timeout);
        n_elapsed = (w_elap_base < pidpc_pkg::ElapMax) ? w_elap_base + 1'b1 : w_elap_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
            r_settled  <= '0;
            r_elapsed  <= '0;
        end else if (w_step) begin
            r_prev_err <= w_err;
            r_integ    <= n_integ;
            r_settled  <= n_settled;
            r_elapsed  <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_ctl.err   <= w_err;
            r_ctl.integ <= n_integ;
            r_ctl.deriv <= w_deriv;
            r_ctl.done  <= w_done;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the three gain products
    logic signed [pidpc_pkg::PPropW-1:0] r_p_prop;
    logic signed [pidpc_pkg::PIntW-1:0]  r_p_int;
    logic signed [pidpc_pkg::PDerW-1:0]  r_p_der;
    logic signed [pidpc_pkg::ErrW-1:0]   r_err3;
    logic                                r_done3;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_p_prop <= pidpc_pkg::PPropW'(r_prop_gain)  * pidpc_pkg::PPropW'(r_ctl.err);
            r_p_int  <= pidpc_pkg::PIntW'(r_integ_gain)  * pidpc_pkg::PIntW'(r_ctl.integ);
            r_p_der  <= pidpc_pkg::PDerW'(r_deriv_gain)  * pidpc_pkg::PDerW'(r_ctl.deriv);
            r_err3   <= r_ctl.err;
            r_done3  <= r_ctl.done;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sum, floor shift by 8, saturate to the output limit
    logic signed [pidpc_pkg::SumW-1:0]   w_sum;
    logic signed [pidpc_pkg::ShW-1:0]    w_shift, w_olim;
    logic signed [pidpc_pkg::DriveW-1:0] w_drive;
    logic [pidpc_pkg::DriveW-1:0]        r_drive;
    logic [pidpc_pkg::ErrW-1:0]          r_err_o;
    logic                                r_done_o;

    always_comb begin
        w_sum = pidpc_pkg::SumW'(r_p_prop) + pidpc_pkg::SumW'(r_p_int)
              + pidpc_pkg::SumW'(r_p_der);
        w_shift = w_sum[pidpc_pkg::SumW-1:8];
        w_olim  = {{(pidpc_pkg::ShW-pidpc_pkg::OlimW){1'b0}}, r_out_limit};
        if (w_shift > w_olim)
            w_drive = w_olim[pidpc_pkg::DriveW-1:0];
        else if (w_shift < -w_olim)
            w_drive = pidpc_pkg::DriveW'(-w_olim);
        else
            w_drive = w_shift[pidpc_pkg::DriveW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_o) begin
            r_drive  <= w_drive;
            r_err_o  <= r_err3;
            r_done_o <= r_done3;
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {{(pidpc_pkg::OutDataW-pidpc_pkg::DriveW-pidpc_pkg::ErrW){1'b0}},
                              r_err_o, r_drive};
    assign o_m_axis_tuser  = r_done_o;

endmodule

// File: bench/pid_position_controller_unit_checker.sv
// Scoreboard for the PID position controller: watches the config, input and result
// channels, predicts each tick's drive, done flag and loop error, and counts mismatches.
// Depends on pidpc_pkg.
`timescale 1ns / 100ps

module pid_position_controller_unit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    input  logic                          i_s_axis_tready,
    input  logic [pidpc_pkg::InDataW-1:0] i_s_axis_tdata,
    input  logic                          i_s_axis_tuser,
    input  logic                          i_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [pidpc_pkg::OutDataW-1:0] i_m_axis_tdata,
    input  logic                          i_m_axis_tuser,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [pidpc_pkg::IdxW-1:0]    i_cfg_index,
    input  logic [pidpc_pkg::CfgW-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic [pidpc_pkg::DriveW-1:0] drive;
        logic                         done;
        logic [pidpc_pkg::ErrW-1:0]   loop_err;
    } t_tick_out;

    // Register copy
    longint kp, ki, kd, zone, ilim, olim, tol, tmo;

    // Loop state
    longint last_err, integ_acc;
    int     settled, elapsed;

    t_tick_out expected_ticks[$];
    int        mismatches = 0;
    int        queued = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = queued;

    // One control tick: updates the loop state and returns the expected result
    function automatic t_tick_out pid_tick(input logic [pidpc_pkg::PosW-1:0] sp,
                                           input logic [pidpc_pkg::PosW-1:0] ms,
                                           input logic start);
        longint    err, mag, deriv, acc, drv;
        t_tick_out res;
        if (start) begin
            settled = 0;
            elapsed = 0;
        end
        err = longint'($signed(sp)) - longint'($signed(ms));
        mag = (err < 0) ? -err : err;

        // zoned integral, then clamp
        if (mag < zone)
            integ_acc = integ_acc + err;
        else
            integ_acc = 0;
        if (integ_acc > ilim)
            integ_acc = ilim;
        if (integ_acc < -ilim)
            integ_acc = -ilim;

        deriv    = err - last_err;
        last_err = err;

        // Q8.8 sum, floor shift, saturate
        acc = kp * err + ki * integ_acc + kd * deriv;
        drv = acc >>> 8;
        if (drv > olim)
            drv = olim;
        if (drv < -olim)
            drv = -olim;

        // settle / timeout; elapsed is checked before it counts this tick
        if (mag <= tol && settled < int'(pidpc_pkg::SettleMax))
            settled++;
        res.done = (settled >= int'(pidpc_pkg::SettleCount)) || (longint'(elapsed) > tmo);
        if (elapsed < int'(pidpc_pkg::ElapMax))
            elapsed++;

        res.drive    = drv[pidpc_pkg::DriveW-1:0];
        res.loop_err = err[pidpc_pkg::ErrW-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    // Sample all three channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_tick_out want;
        if (!i_rst_n) begin
            kp        = longint'($signed(pidpc_pkg::RstPropGain));
            ki        = longint'($signed(pidpc_pkg::RstIntegGain));
            kd        = longint'($signed(pidpc_pkg::RstDerivGain));
            zone      = longint'(pidpc_pkg::RstIntZone);
            ilim      = longint'(pidpc_pkg::RstIntLimit);
            olim      = longint'(pidpc_pkg::RstOutLimit);
            tol       = longint'(pidpc_pkg::RstSettleTol);
            tmo       = longint'(pidpc_pkg::RstTimeout);
            last_err  = 0;
            integ_acc = 0;
            settled   = 0;
            elapsed   = 0;
            expected_ticks.delete();
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pidpc_pkg::RegPropGain:  kp   = longint'($signed(i_cfg_data));
                    pidpc_pkg::RegIntegGain: ki   = longint'($signed(i_cfg_data));
                    pidpc_pkg::RegDerivGain: kd   = longint'($signed(i_cfg_data));
                    pidpc_pkg::RegIntZone:   zone = longint'(i_cfg_data);
                    pidpc_pkg::RegIntLimit:  ilim = longint'(i_cfg_data);
                    pidpc_pkg::RegOutLimit:
                        olim = longint'(i_cfg_data[pidpc_pkg::OlimW-1:0]);
                    pidpc_pkg::RegSettleTol: tol  = longint'(i_cfg_data);
                    pidpc_pkg::RegTimeout:   tmo  = longint'(i_cfg_data);
                    default: ;
                endcase
            end

            // result beat against the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_ticks.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with none expected, expected none, got %h/%b",
                             $time, i_m_axis_tdata, i_m_axis_tuser);
                end else begin
                    want = expected_ticks.pop_front();
                    if (i_m_axis_tdata[pidpc_pkg::DriveW-1:0] !== want.drive)
                        flag_mismatch("drive", $signed(want.drive),
                                      $signed(i_m_axis_tdata[pidpc_pkg::DriveW-1:0]));
                    if (i_m_axis_tdata[pidpc_pkg::DriveW +: pidpc_pkg::ErrW] !== want.loop_err)
                        flag_mismatch("loop_error", $signed(want.loop_err),
                                      $signed(i_m_axis_tdata[pidpc_pkg::DriveW +:
                                                             pidpc_pkg::ErrW]));
                    if (i_m_axis_tdata[pidpc_pkg::OutDataW-1:pidpc_pkg::DriveW+pidpc_pkg::ErrW]
                        !== '0)
                        flag_mismatch("tdata padding", 0,
                                      i_m_axis_tdata[pidpc_pkg::OutDataW-1:
                                                     pidpc_pkg::DriveW+pidpc_pkg::ErrW]);
                    if (i_m_axis_tuser !== want.done)
                        flag_mismatch("done_res", want.done, i_m_axis_tuser);
                end
            end

            // input beat: tdata [23:0] setpoint, [47:24] measured; tuser move_start
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_ticks.push_back(
                    pid_tick(i_s_axis_tdata[pidpc_pkg::PosW-1:0],
                             i_s_axis_tdata[2*pidpc_pkg::PosW-1:pidpc_pkg::PosW],
                             i_s_axis_tuser));
        end
        queued = expected_ticks.size();
    end

endmodule

// File: bench/pid_position_controller_unit_test.sv
// Testbench top for the PID position controller: clock, reset, directed and random
// control ticks under changing register settings, random stalls, and the verdict.
// Depends on pidpc_pkg, pid_position_controller_unit and its checker.
`timescale 1ns / 100ps

module pid_position_controller_unit_test;

    localparam longint PosMax      = 8388607;
    localparam longint PosMin      = -8388608;
    localparam int     RandomTicks = 1050;
    localparam int     SoakTicks   = 100;
    localparam int     DrainCycles = 12;
    localparam longint RunLimitNs  = 20000000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [pidpc_pkg::InDataW-1:0]  i_s_axis_tdata = '0;
    logic                           i_s_axis_tuser = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [pidpc_pkg::OutDataW-1:0] o_m_axis_tdata;
    logic                           o_m_axis_tuser;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [pidpc_pkg::IdxW-1:0]     i_cfg_index = '0;
    logic [pidpc_pkg::CfgW-1:0]     i_cfg_data = '0;

    int fail_count;
    int pending;
    int tick_count = 0;
    int src_gap_max = 19;
    int sink_gap_max = 19;

    always #6 i_clk = ~i_clk;

    pid_position_controller_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    pid_position_controller_unit_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // One tick beat; positions saturate to the 24-bit range. Called and returns at negedge.
    task automatic send_tick(input longint sp, input longint ms, input logic start);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (sp > PosMax) sp = PosMax;
        if (sp < PosMin) sp = PosMin;
        if (ms > PosMax) ms = PosMax;
        if (ms < PosMin) ms = PosMin;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ms[pidpc_pkg::PosW-1:0], sp[pidpc_pkg::PosW-1:0]};
        i_s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        tick_count++;
    endtask

    // Input side quiet and every expected result back
    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [pidpc_pkg::IdxW-1:0] idx,
                           input logic [pidpc_pkg::CfgW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic [pidpc_pkg::CfgW-1:0] kp, ki, kd, zone, ilim,
                               olim, tol, tmo);
        put_reg(pidpc_pkg::RegPropGain, kp);
        put_reg(pidpc_pkg::RegIntegGain, ki);
        put_reg(pidpc_pkg::RegDerivGain, kd);
        put_reg(pidpc_pkg::RegIntZone, zone);
        put_reg(pidpc_pkg::RegIntLimit, ilim);
        put_reg(pidpc_pkg::RegOutLimit, olim);
        put_reg(pidpc_pkg::RegSettleTol, tol);
        put_reg(pidpc_pkg::RegTimeout, tmo);
        i_cfg_valid <= 1'b0;
    endtask

    // Gains lean on the extremes and on small values that keep the drive off the rails
    function automatic logic [pidpc_pkg::CfgW-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0: pick_gain = 16'h8000;
            1: pick_gain = 16'h7FFF;
            2: pick_gain = 16'h0000;
            3: pick_gain = pidpc_pkg::CfgW'($urandom_range(0, 1023) - 512);
            default: pick_gain = pidpc_pkg::CfgW'($urandom);
        endcase
    endfunction

    // Result side: random stall before each result
    initial begin : sink_side
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, sink_gap_max);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : run_limit
        #(RunLimitNs);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [pidpc_pkg::CfgW-1:0] kp, ki, kd, zone, ilim, olim, tol, tmo;
        logic [pidpc_pkg::PosW-1:0] rnd_a, rnd_b;
        longint                     target, e0, err;
        int                         len, tail, amp, phase_end;
        logic                       lead;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero error, both error extremes, unit errors
        send_tick(0, 0, 1'b1);
        send_tick(PosMax, PosMin, 1'b0);
        send_tick(PosMin, PosMax, 1'b0);
        send_tick(-1, 0, 1'b0);
        send_tick(1, 0, 1'b0);

        // Tiny gain shows floor rounding; zero timeout ends the move on its second tick
        wait_quiet();
        load_config(16'd1, 16'd0, 16'd0, 16'd0, 16'd1000, 16'd127, 16'd0, 16'd0);
        send_tick(0, -1, 1'b1);
        send_tick(-1, 0, 1'b0);
        send_tick(0, 0, 1'b1);

        // Zero output limit (upper data bits set) and zero integral limit
        wait_quiet();
        load_config(16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 16'hFF80,
                    16'hFFFF, 16'hFFFF);
        send_tick(100, -100, 1'b1);
        send_tick(PosMax, 0, 1'b0);
        send_tick(0, PosMax, 1'b0);

        // Extreme gains; integral hits both clamps, zone edge clears it
        wait_quiet();
        load_config(16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'd127,
                    16'd0, 16'hFFFF);
        send_tick(65534, 0, 1'b1);
        send_tick(65534, 0, 1'b0);
        send_tick(-65535, 0, 1'b0);
        send_tick(-65534, 0, 1'b0);
        send_tick(-65534, 0, 1'b0);
        send_tick(PosMax, PosMin, 1'b0);

        // Random phases: fresh settings, then mostly well-formed moves
        phase_end = tick_count;
        while (tick_count < phase_end + RandomTicks) begin : phase
            int phase_stop;
            wait_quiet();
            kp = pick_gain();
            ki = pick_gain();
            kd = pick_gain();
            case ($urandom_range(0, 3))
                0: zone = 16'h0000;
                1: zone = 16'hFFFF;
                2: zone = pidpc_pkg::CfgW'($urandom_range(1, 3000));
                default: zone = pidpc_pkg::CfgW'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0: ilim = 16'h0000;
                1: ilim = 16'hFFFF;
                2: ilim = pidpc_pkg::CfgW'($urandom_range(1, 2000));
                default: ilim = pidpc_pkg::CfgW'($urandom);
            endcase
            olim = pidpc_pkg::CfgW'($urandom);
            case ($urandom_range(0, 2))
                0: olim[pidpc_pkg::OlimW-1:0] = '0;
                1: olim[pidpc_pkg::OlimW-1:0] = '1;
                default: olim[pidpc_pkg::OlimW-1:0] = pidpc_pkg::OlimW'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 4))
                0: tol = 16'h0000;
                1: tol = 16'hFFFF;
                2: tol = pidpc_pkg::CfgW'($urandom);
                default: tol = pidpc_pkg::CfgW'($urandom_range(0, 10));
            endcase
            case ($urandom_range(0, 3))
                0: tmo = 16'h0000;
                1: tmo = 16'hFFFF;
                2: tmo = pidpc_pkg::CfgW'($urandom_range(0, 60));
                default: tmo = pidpc_pkg::CfgW'($urandom);
            endcase
            load_config(kp, ki, kd, zone, ilim, olim, tol, tmo);
            src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 19;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;

            phase_stop = tick_count + int'($urandom_range(40, 150));
            while (tick_count < phase_stop) begin
                if ($urandom_range(0, 4) == 0) begin
                    // noise tick, any bit pattern
                    rnd_a = pidpc_pkg::PosW'($urandom);
                    rnd_b = pidpc_pkg::PosW'($urandom);
                    send_tick($signed(rnd_a), $signed(rnd_b), $urandom_range(0, 3) == 0);
                end else begin
                    // move: start tick, decaying error, then a tail near zero
                    rnd_a = pidpc_pkg::PosW'($urandom);
                    target = longint'($signed(rnd_a));
                    case ($urandom_range(0, 3))
                        0: e0 = longint'($urandom_range(0, 16)) - 8;
                        1: e0 = longint'($urandom_range(0, 4000)) - 2000;
                        2: e0 = longint'($urandom_range(0, 400000)) - 200000;
                        default: e0 = longint'($urandom_range(0, 33554430)) - 16777215;
                    endcase
                    len  = $urandom_range(1, 30);
                    tail = $urandom_range(0, 40);
                    amp  = $urandom_range(0, 6);
                    lead = ($urandom_range(0, 7) != 0);   // some moves miss their start flag
                    for (int k = 0; k < len; k++) begin
                        err = e0 * (len - k) / len + longint'($urandom_range(0, 4)) - 2;
                        send_tick(target, target - err, lead && (k == 0));
                    end
                    for (int k = 0; k < tail; k++) begin
                        err = longint'($urandom_range(0, 2 * amp)) - amp;
                        send_tick(target, target - err, 1'b0);
                    end
                end
            end
        end

        // Long move without stalls: runs well past a short timeout, never settles
        wait_quiet();
        load_config(pick_gain(), pick_gain(), pick_gain(), pidpc_pkg::CfgW'($urandom),
                    pidpc_pkg::CfgW'($urandom), pidpc_pkg::CfgW'($urandom),
                    16'd0, 16'd40);
        src_gap_max  = 0;
        sink_gap_max = 0;
        rnd_a = pidpc_pkg::PosW'($urandom);
        target = longint'($signed(rnd_a));
        for (int k = 0; k < SoakTicks; k++) begin
            err = longint'($urandom_range(1, 1000));
            if ($urandom_range(0, 1) == 0)
                err = -err;
            send_tick(target, target - err, k == 0);
        end

        wait_quiet();
        repeat (DrainCycles) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
